// ===== hw/rtl/afp_pkg.sv =====
// ----------------------------------------------------------------------------
// afp_pkg: shared constants and helpers for the airfoil point classifier
// Widths of the coordinate path, divider and square-root pipelines, the
// register index codes and the thickness polynomial coefficients.
// ----------------------------------------------------------------------------
package afp_pkg;

	// coordinate format, signed Q16.16
	localparam int COORD_WIDTH = 32;
	localparam int CFG_W       = (COORD_WIDTH > 31) ? COORD_WIDTH : 31;
	localparam int IN_W        = ((2 * COORD_WIDTH + 7) / 8) * 8;
	localparam int OUT_W       = 8;
	localparam int REG_IDX_W   = 3;

	// register index codes
	typedef enum logic [REG_IDX_W-1:0] {
		REG_MAX_CAMBER  = 3'd0,
		REG_CAMBER_POS  = 3'd1,
		REG_THICKNESS   = 3'd2,
		REG_ORIGIN_X    = 3'd3,
		REG_ORIGIN_Y    = 3'd4,
		REG_CHORD       = 3'd5,
		REG_COS_ANGLE   = 3'd6,
		REG_SIN_ANGLE   = 3'd7
	} reg_idx_t;

	// Q0.30 fraction
	localparam int Q30_FRAC = 30;
	localparam int Q30_W    = Q30_FRAC + 1;
	localparam logic [Q30_W-1:0] ONE_Q30 = Q30_W'(64'd1 << Q30_FRAC);

	// restoring divider: one setup step plus Q30_FRAC shift steps
	localparam int DIV_W    = 62;
	localparam int DIV_QW   = Q30_W;
	localparam int DIV_BITS = Q30_FRAC;
	localparam int DIV_SPS  = 2;
	localparam int DIV_ST   = (DIV_BITS + 1 + DIV_SPS - 1) / DIV_SPS;

	// digit-by-digit square root of x * 2^30
	localparam int SQ_VW    = 64;
	localparam int SQ_RW    = 35;
	localparam int SQ_ROOTW = SQ_VW / 2;
	localparam int SQ_SPS   = 2;
	localparam int SQ_ST    = SQ_ROOTW / SQ_SPS;

	// thickness polynomial coefficients, round(k * 2^30)
	localparam logic [Q30_W-1:0] K_SQRT = Q30_W'(318793948);
	localparam logic [Q30_W-1:0] K_LIN  = Q30_W'(135291470);
	localparam logic [Q30_W-1:0] K_SQ   = Q30_W'(377527625);
	localparam logic [Q30_W-1:0] K_CUBE = Q30_W'(305264801);
	localparam logic [Q30_W-1:0] K_QUAD = Q30_W'(108984795);

	// floor(a * b / 2^30), result known to fit Q0.30 plus the integer bit
	function automatic logic [Q30_W-1:0] mul_q30(input logic [Q30_W-1:0] a,
			input logic [Q30_W-1:0] b);
		logic [2*Q30_W-1:0] p;
		p = a * b;
		return p[Q30_FRAC+Q30_W-1:Q30_FRAC];
	endfunction

endpackage

// ===== hw/rtl/airfoil_point_classifier.sv =====
// ----------------------------------------------------------------------------
// airfoil_point_classifier: NACA 4-digit point-in-profile test
// A point passes through the 40 pipeline stages, which advance together,
// and then the output register before its result shows on m_tvalid.
// Throughput: one point per cycle while the skid is empty; a one-beat skid
// after the output register absorbs a stall.
// Reset clears all valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module airfoil_point_classifier (
	input  logic                              clk,
	input  logic                              arst_n,
	// point_x, point_y
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [afp_pkg::IN_W-1:0]          s_tdata,
	// solid, within_chord
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [afp_pkg::OUT_W-1:0]         m_tdata,
	// configuration writes
	input  logic                              cfg_we,
	input  logic [afp_pkg::REG_IDX_W-1:0]     cfg_addr,
	input  logic [afp_pkg::CFG_W-1:0]         cfg_wdata
);
	import afp_pkg::*;

	localparam int NUM_ST = 40;
	localparam int DX_W   = COORD_WIDTH + 1;
	localparam int PR_W   = DX_W + 18;
	localparam int XL_W   = PR_W + 1;
	localparam int CD_W   = 47;
	localparam int MC_W   = 47;
	localparam int TC5_W  = 50;
	localparam int NEG_W  = Q30_W + 2;
	localparam int POS_W  = Q30_W + 1;
	localparam int PM_W   = NEG_W + 1;
	localparam int MAG_W  = PM_W - 1;
	localparam int YTH_W  = TC5_W - 25;
	localparam int YT_PW  = 25 + MAG_W;
	localparam int YT_SW  = YTH_W + MAG_W + 26;
	localparam int YTM_W  = 51;
	localparam int YC_PW  = 24 + Q30_W;
	localparam int YC_SW  = MC_W + Q30_W + 1;
	localparam int YC_W   = 48;
	localparam int D_W    = XL_W + 2;

	// configuration registers
	logic [15:0]                max_camber_q;
	logic [15:0]                camber_position_q;
	logic [15:0]                thickness_q;
	logic signed [COORD_WIDTH-1:0] origin_x_q;
	logic signed [COORD_WIDTH-1:0] origin_y_q;
	logic [30:0]                chord_length_q;
	logic signed [17:0]         cos_angle_q;
	logic signed [17:0]         sin_angle_q;

	// products of configuration values
	logic [MC_W-1:0]            mc_q;
	logic [MC_W-1:0]            tc_q;
	logic [TC5_W-1:0]           tc5_q;
	logic [DIV_W-1:0]           p30sq_q;
	logic [DIV_W-1:0]           q30sq_q;

	logic [CD_W-1:0]            cden;
	logic [29:0]                p30;
	logic [30:0]                two_p30;

	// pipeline control
	logic                       en;
	logic [NUM_ST:1]            vld_s;
	logic                       out_vld_q, out_solid_q, out_within_q;
	logic                       skd_vld_q, skd_solid_q, skd_within_q;
	logic                       in_v, pop, solid_n;

	// datapath stages
	logic signed [DX_W-1:0]     dx_s1, dy_s1;
	logic signed [PR_W-1:0]     pxc_s2, pys_s2, pyc_s2, pxs_s2;
	logic signed [XL_W-1:0]     xl_s3;
	logic signed [XL_W-1:0]     yl_s [3:39];
	logic                       within_s [4:40];
	logic [Q30_W-1:0]           x_s19;
	logic [Q30_W-1:0]           x2_s20, xd_s20;
	logic [Q30_W-1:0]           ca_s20;
	logic [31:0]                cb_s20;
	logic [DIV_W-1:0]           cdn_s20;
	logic [Q30_W-1:0]           x3_s21, x2d_s21, xd_s21;
	logic [DIV_W-1:0]           cnum_s21, cdn_s21;
	logic [Q30_W-1:0]           x4_s22, x3d_s22, x2d_s22, xd_s22;
	logic [Q30_W-1:0]           tlin_s23, tsq_s23, tcube_s23, tquad_s23;
	logic [NEG_W-1:0]           neg_s [24:36];
	logic [Q30_W-1:0]           cube_s [24:36];
	logic [Q30_W-1:0]           root_s35;
	logic [Q30_W-1:0]           tsqrt_s36;
	logic signed [PM_W-1:0]     pm_s37;
	logic [Q30_W-1:0]           ratio_s37;
	logic [MAG_W-1:0]           mag_s38;
	logic                       ng_s38, ng_s39, ng_s40;
	logic [YC_PW-1:0]           ycl_s38;
	logic [YC_PW-1:0]           ych_s38;
	logic [YT_PW-1:0]           ytl_s39, yth_s39;
	logic [YC_W-1:0]            yc_s39;
	logic [YTM_W-1:0]           ytm_s40;
	logic signed [D_W-1:0]      d_s40;

	// combinational helpers
	logic [Q30_W-1:0]           ca_n;
	logic [31:0]                cb_n;
	logic [DIV_W-1:0]           cdn_n;
	logic [YC_SW-1:0]           yc_sum;
	logic [YT_SW-1:0]           yt_sum;
	logic [YC_W-1:0]            yc_use;
	logic signed [D_W:0]        d_plus;

	assign cden    = {chord_length_q, 16'b0};
	assign p30     = {camber_position_q, 14'b0};
	assign two_p30 = {camber_position_q, 15'b0};

	// configuration write port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_camber_q      <= '0;
			camber_position_q <= '0;
			thickness_q       <= 16'd7864;
			origin_x_q        <= '0;
			origin_y_q        <= '0;
			chord_length_q    <= 31'd65536;
			cos_angle_q       <= 18'sd65536;
			sin_angle_q       <= '0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_addr))
				REG_MAX_CAMBER: max_camber_q      <= cfg_wdata[15:0];
				REG_CAMBER_POS: camber_position_q <= cfg_wdata[15:0];
				REG_THICKNESS:  thickness_q       <= cfg_wdata[15:0];
				REG_ORIGIN_X:   origin_x_q        <= cfg_wdata[COORD_WIDTH-1:0];
				REG_ORIGIN_Y:   origin_y_q        <= cfg_wdata[COORD_WIDTH-1:0];
				REG_CHORD:      chord_length_q    <= cfg_wdata[30:0];
				REG_COS_ANGLE:  cos_angle_q       <= cfg_wdata[17:0];
				REG_SIN_ANGLE:  sin_angle_q       <= cfg_wdata[17:0];
				default: ;
			endcase
		end
	end

	// derived constants, refreshed every cycle
	always_ff @(posedge clk) begin
		mc_q    <= max_camber_q * chord_length_q;
		tc_q    <= thickness_q * chord_length_q;
		tc5_q   <= TC5_W'({tc_q, 2'b00}) + TC5_W'(tc_q);
		p30sq_q <= DIV_W'({32'(camber_position_q * camber_position_q), 28'b0});
		q30sq_q <= DIV_W'({34'((17'h10000 - 17'(camber_position_q)) *
			(17'h10000 - 17'(camber_position_q))), 28'b0});
	end

	// global advance: stall only when the skid holds a beat
	assign en       = !skd_vld_q;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[NUM_ST-1:1], s_tvalid};
		end
	end

	// stage 1: offset from the leading edge
	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= DX_W'($signed(s_tdata[COORD_WIDTH-1:0])) - DX_W'(origin_x_q);
			dy_s1 <= DX_W'($signed(s_tdata[2*COORD_WIDTH-1:COORD_WIDTH])) -
				DX_W'(origin_y_q);
		end
	end

	// stage 2: rotation products; stage 3: rotated coordinates
	always_ff @(posedge clk) begin
		if (en) begin
			pxc_s2   <= dx_s1 * cos_angle_q;
			pys_s2   <= dy_s1 * sin_angle_q;
			pyc_s2   <= dy_s1 * cos_angle_q;
			pxs_s2   <= dx_s1 * sin_angle_q;
			xl_s3    <= XL_W'(pxc_s2) + XL_W'(pys_s2);
			yl_s[3]  <= XL_W'(pyc_s2) - XL_W'(pxs_s2);
			within_s[4] <= (chord_length_q != '0) && !xl_s3[XL_W-1] &&
				(xl_s3[XL_W-2:0] <= (XL_W-1)'(cden));
		end
	end

	// delay lines for values needed at the end
	generate
		for (genvar k = 4; k <= 39; k++) begin : g_yl
			always_ff @(posedge clk) begin
				if (en) yl_s[k] <= yl_s[k-1];
			end
		end
		for (genvar k = 5; k <= 40; k++) begin : g_wc
			always_ff @(posedge clk) begin
				if (en) within_s[k] <= within_s[k-1];
			end
		end
		for (genvar k = 25; k <= 36; k++) begin : g_poly
			always_ff @(posedge clk) begin
				if (en) begin
					neg_s[k]  <= neg_s[k-1];
					cube_s[k] <= cube_s[k-1];
				end
			end
		end
	endgenerate

	// stages 4..19: normalized chord position x = xl / chord in Q0.30
	afp_div u_div_x (
		.clk (clk),
		.en  (en),
		.num (DIV_W'(xl_s3[XL_W-2:0])),
		.den (DIV_W'(cden)),
		.quo (x_s19)
	);

	// stages 20..35: sqrt(x)
	afp_sqrt u_sqrt (
		.clk  (clk),
		.en   (en),
		.rad  (x_s19),
		.root (root_s35)
	);

	// camber line operands, fore or aft of the max camber point
	always_comb begin
		if (x_s19 < Q30_W'(p30)) begin
			ca_n  = x_s19;
			cb_n  = 32'(two_p30) - 32'(x_s19);
			cdn_n = p30sq_q;
		end else begin
			ca_n  = ONE_Q30 - x_s19;
			cb_n  = 32'(ONE_Q30) + 32'(x_s19) - 32'(two_p30);
			cdn_n = q30sq_q;
		end
	end

	// stages 20..24: powers of x and polynomial terms
	always_ff @(posedge clk) begin
		if (en) begin
			x2_s20    <= mul_q30(x_s19, x_s19);
			xd_s20    <= x_s19;
			ca_s20    <= ca_n;
			cb_s20    <= cb_n;
			cdn_s20   <= cdn_n;
			x3_s21    <= mul_q30(x2_s20, xd_s20);
			x2d_s21   <= x2_s20;
			xd_s21    <= xd_s20;
			cnum_s21  <= DIV_W'(ca_s20 * cb_s20);
			cdn_s21   <= cdn_s20;
			x4_s22    <= mul_q30(x3_s21, xd_s21);
			x3d_s22   <= x3_s21;
			x2d_s22   <= x2d_s21;
			xd_s22    <= xd_s21;
			tlin_s23  <= mul_q30(K_LIN, xd_s22);
			tsq_s23   <= mul_q30(K_SQ, x2d_s22);
			tcube_s23 <= mul_q30(K_CUBE, x3d_s22);
			tquad_s23 <= mul_q30(K_QUAD, x4_s22);
			neg_s[24] <= NEG_W'(tlin_s23) + NEG_W'(tsq_s23) + NEG_W'(tquad_s23);
			cube_s[24] <= tcube_s23;
		end
	end

	// stages 22..37: camber ratio
	afp_div u_div_c (
		.clk (clk),
		.en  (en),
		.num (cnum_s21),
		.den (cdn_s21),
		.quo (ratio_s37)
	);

	// stages 36..40: thickness, camber and difference
	always_ff @(posedge clk) begin
		if (en) begin
			tsqrt_s36 <= mul_q30(K_SQRT, root_s35);
			pm_s37    <= $signed(PM_W'(POS_W'(tsqrt_s36) + POS_W'(cube_s[36]))) -
				$signed(PM_W'(neg_s[36]));
			ng_s38    <= pm_s37[PM_W-1];
			mag_s38   <= pm_s37[PM_W-1] ? MAG_W'(-pm_s37) : MAG_W'(pm_s37);
			ycl_s38   <= YC_PW'(mc_q[23:0] * ratio_s37);
			ych_s38   <= YC_PW'(mc_q[MC_W-1:24] * ratio_s37);
			ng_s39    <= ng_s38;
			ytl_s39   <= YT_PW'(tc5_q[24:0] * mag_s38);
			yth_s39   <= YT_PW'(tc5_q[TC5_W-1:25] * mag_s38);
			yc_s39    <= yc_sum[Q30_FRAC+YC_W-1:Q30_FRAC];
			ng_s40    <= ng_s39;
			ytm_s40   <= yt_sum[Q30_FRAC+YTM_W-1:Q30_FRAC];
			d_s40     <= D_W'(yl_s[39]) - $signed(D_W'(yc_use));
		end
	end

	assign yc_sum = YC_SW'({ych_s38, 24'b0}) + YC_SW'(ycl_s38);
	assign yt_sum = YT_SW'({yth_s39, 25'b0}) + YT_SW'(ytl_s39);
	assign yc_use = (camber_position_q == '0) ? '0 : yc_s39;

	// solid when |d| <= yt; a negative thickness only admits d == 0 with yt == 0
	always_comb begin
		d_plus = (D_W+1)'(d_s40) + $signed((D_W+1)'(ytm_s40));
		if (ng_s40)
			solid_n = within_s[40] && (ytm_s40 == '0) && (d_s40 == '0);
		else
			solid_n = within_s[40] && (d_s40 <= $signed(D_W'(ytm_s40))) &&
				!d_plus[D_W];
	end

	// output register and skid
	assign in_v = en && vld_s[NUM_ST];
	assign pop  = out_vld_q && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			skd_vld_q <= 1'b0;
		end else if (skd_vld_q) begin
			if (pop) skd_vld_q <= 1'b0;
		end else if (!out_vld_q || pop) begin
			out_vld_q <= in_v;
		end else if (in_v) begin
			skd_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skd_vld_q) begin
			if (pop) begin
				out_solid_q  <= skd_solid_q;
				out_within_q <= skd_within_q;
			end
		end else if (!out_vld_q || pop) begin
			out_solid_q  <= solid_n;
			out_within_q <= within_s[40];
		end else begin
			skd_solid_q  <= solid_n;
			skd_within_q <= within_s[40];
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = OUT_W'({out_within_q, out_solid_q});

	// checks
	a_skd_has_out: assert property (@(posedge clk) disable iff (!arst_n)
		skd_vld_q |-> out_vld_q)
		else $error("skid holds a beat while output register is empty");

	a_skd_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		skd_vld_q |-> !s_tready)
		else $error("input taken while skid is full");

	a_solid_in_chord: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[0]) |-> m_tdata[1])
		else $error("solid point reported outside the chord");

	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(en && vld_s[NUM_ST]) |=> m_tvalid)
		else $error("finished beat lost at the output");

endmodule

// ===== hw/rtl/afp_div.sv =====
// ----------------------------------------------------------------------------
// afp_div: pipelined fractional divider
// Computes floor(num * 2^30 / den) for num <= den, restoring form, up to two
// quotient bits per stage. Every stage advances on the shared enable.
// ----------------------------------------------------------------------------
module afp_div (
	input  logic                        clk,
	input  logic                        en,
	input  logic [afp_pkg::DIV_W-1:0]   num,
	input  logic [afp_pkg::DIV_W-1:0]   den,
	output logic [afp_pkg::DIV_QW-1:0]  quo
);
	import afp_pkg::*;

	logic [DIV_W-1:0]  rem_s  [DIV_ST];
	logic [DIV_W-1:0]  den_s  [DIV_ST];
	logic [DIV_QW-1:0] quo_s  [DIV_ST];
	logic [DIV_W-1:0]  rem_in [DIV_ST];
	logic [DIV_W-1:0]  den_in [DIV_ST];
	logic [DIV_QW-1:0] quo_in [DIV_ST];
	logic [DIV_W-1:0]  rem_n  [DIV_ST];
	logic [DIV_QW-1:0] quo_n  [DIV_ST];

	// first stage takes the operands
	assign rem_in[0] = num;
	assign den_in[0] = den;
	assign quo_in[0] = '0;

	generate
		for (genvar j = 0; j < DIV_ST; j++) begin : g_st
			if (j > 0) begin : g_link
				assign rem_in[j] = rem_s[j-1];
				assign den_in[j] = den_s[j-1];
				assign quo_in[j] = quo_s[j-1];
			end

			// up to two subtract-and-compare steps; step 0 has no shift
			always_comb begin : step
				logic [DIV_W:0]    rt;
				logic [DIV_W-1:0]  r;
				logic [DIV_QW-1:0] q;
				int                t;
				r = rem_in[j];
				q = quo_in[j];
				rt = '0;
				for (int k = 0; k < DIV_SPS; k++) begin
					t = j * DIV_SPS + k;
					if (t <= DIV_BITS) begin
						rt = (t == 0) ? {1'b0, r} : {r, 1'b0};
						if (rt >= {1'b0, den_in[j]}) begin
							rt = rt - {1'b0, den_in[j]};
							q  = {q[DIV_QW-2:0], 1'b1};
						end else begin
							q  = {q[DIV_QW-2:0], 1'b0};
						end
						r = rt[DIV_W-1:0];
					end
				end
				rem_n[j] = r;
				quo_n[j] = q;
			end

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[j] <= rem_n[j];
					den_s[j] <= den_in[j];
					quo_s[j] <= quo_n[j];
				end
			end
		end
	endgenerate

	assign quo = quo_s[DIV_ST-1];

endmodule

// ===== hw/rtl/afp_sqrt.sv =====
// ----------------------------------------------------------------------------
// afp_sqrt: pipelined integer square root
// Returns floor(sqrt(rad * 2^30)) by the digit-by-digit method, two root
// bits per stage. Every stage advances on the shared enable.
// ----------------------------------------------------------------------------
module afp_sqrt (
	input  logic                        clk,
	input  logic                        en,
	input  logic [afp_pkg::Q30_W-1:0]   rad,
	output logic [afp_pkg::Q30_W-1:0]   root
);
	import afp_pkg::*;

	logic [Q30_W-1:0]    rad_s  [SQ_ST];
	logic [SQ_RW-1:0]    rem_s  [SQ_ST];
	logic [SQ_ROOTW-1:0] rt_s   [SQ_ST];
	logic [Q30_W-1:0]    rad_in [SQ_ST];
	logic [SQ_RW-1:0]    rem_in [SQ_ST];
	logic [SQ_ROOTW-1:0] rt_in  [SQ_ST];
	logic [SQ_RW-1:0]    rem_n  [SQ_ST];
	logic [SQ_ROOTW-1:0] rt_n   [SQ_ST];

	assign rad_in[0] = rad;
	assign rem_in[0] = '0;
	assign rt_in[0]  = '0;

	generate
		for (genvar j = 0; j < SQ_ST; j++) begin : g_st
			if (j > 0) begin : g_link
				assign rad_in[j] = rad_s[j-1];
				assign rem_in[j] = rem_s[j-1];
				assign rt_in[j]  = rt_s[j-1];
			end

			// bring down two radicand bits, try root*4+1
			always_comb begin : step
				logic [SQ_VW-1:0]    vv;
				logic [SQ_RW-1:0]    rm;
				logic [SQ_RW-1:0]    trial;
				logic [SQ_ROOTW-1:0] rt;
				int                  i;
				vv = SQ_VW'({rad_in[j], {Q30_FRAC{1'b0}}});
				rm = rem_in[j];
				rt = rt_in[j];
				for (int k = 0; k < SQ_SPS; k++) begin
					i = j * SQ_SPS + k;
					rm = {rm[SQ_RW-3:0], vv[SQ_VW-1-2*i -: 2]};
					trial = SQ_RW'({rt, 2'b01});
					if (rm >= trial) begin
						rm = rm - trial;
						rt = {rt[SQ_ROOTW-2:0], 1'b1};
					end else begin
						rt = {rt[SQ_ROOTW-2:0], 1'b0};
					end
				end
				rem_n[j] = rm;
				rt_n[j]  = rt;
			end

			always_ff @(posedge clk) begin
				if (en) begin
					rad_s[j] <= rad_in[j];
					rem_s[j] <= rem_n[j];
					rt_s[j]  <= rt_n[j];
				end
			end
		end
	endgenerate

	assign root = rt_s[SQ_ST-1][Q30_W-1:0];

endmodule
